>>> rtl/dsfc_pkg.sv
package dsfc_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int CHANNELS = 4;
  localparam int LANES = 4;

  localparam logic [10:0] CMD_OFFSET = 11'd48;
  localparam logic [10:0] MAX_THROTTLE = 11'd1999;
  localparam logic [5:0] SAVE_CODE = 6'd12;
  localparam logic [3:0] SAVE_REPEATS = 4'd10;
  localparam logic [2:0] ACTIVE_CHANNELS_RESET = 3'd4;

  typedef enum logic [0:0] {
    OP_FRAME   = 1'b0,
    OP_ENQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_ARMED = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [10:0] throttle_0;
    logic [10:0] throttle_1;
    logic [10:0] throttle_2;
    logic [10:0] throttle_3;
    logic        armed;
    logic [5:0]  cmd_code;
    logic [3:0]  repeat_count;
    logic [3:0]  target_mask;
    logic        save_after;
  } item_t;

  typedef struct packed {
    logic [10:0] frame_value_0;
    logic [10:0] frame_value_1;
    logic [10:0] frame_value_2;
    logic [10:0] frame_value_3;
    logic        cmd_carried;
    status_t     enqueue_status;
    logic [3:0]  queue_level;
  } result_t;

  typedef struct packed {
    logic       save;
    logic [3:0] mask;
    logic [3:0] repeats;
    logic [5:0] code;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

>>> rtl/dsfc_ram.sv
module dsfc_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/dsfc_cmd_fifo.sv
module dsfc_cmd_fifo #(
  parameter int DEPTH = dsfc_pkg::QUEUE_DEPTH_DEF,
  parameter int AW = $clog2(DEPTH),
  parameter int CW = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  dsfc_pkg::fifo_ctl_t ctl,
  input  dsfc_pkg::entry_t   push_data,
  output dsfc_pkg::entry_t   head_entry,
  output logic [CW-1:0]      count,
  output logic [CW-1:0]      count_next
);

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail;
  logic [AW-1:0] tail_next;
  logic          byp_valid;
  dsfc_pkg::entry_t byp_data;
  dsfc_pkg::entry_t rdata;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_next = head;
    tail_next = tail;
    count_next = count;
    if (ctl.clear) begin
      head_next = '0;
      tail_next = '0;
      count_next = '0;
    end else if (ctl.push) begin
      tail_next = wrap_inc(tail);
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      head_next = wrap_inc(head);
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
      byp_valid <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      count <= count_next;
      byp_valid <= ctl.push && (tail == head_next);
    end
  end

  // write landing on the address being read this edge
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      byp_data <= push_data;
    end
  end

  dsfc_ram #(
    .WIDTH($bits(dsfc_pkg::entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.push),
    .waddr(tail),
    .wdata(push_data),
    .raddr(head_next),
    .rdata(rdata)
  );

  assign head_entry = byp_valid ? byp_data : rdata;

endmodule

>>> rtl/dshot_frame_composer_command_queue.sv
// each accepted item beat is registered and comes out as its result beat in the next cycle
// throughput: one item per cycle; an item is taken only while the result register
// is empty or its waiting beat is taken in the same cycle
// the command queue read is a registered ram read kept one entry ahead
// reset: synchronous rst empties the queue, drops the active command,
// clears the armed history and sets active_channels to 4; queue ram not cleared
module dshot_frame_composer_command_queue #(
  parameter int QUEUE_DEPTH = dsfc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  dsfc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output dsfc_pkg::result_t result
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [2:0] active_channels;
  logic [5:0] act_code;
  logic [3:0] act_repeats;
  logic [3:0] act_mask;
  logic       act_save;
  logic       armed_prev;

  logic [5:0] act_code_next;
  logic [3:0] act_repeats_next;
  logic [3:0] act_mask_next;
  logic       act_save_next;
  logic       armed_prev_next;

  logic                 item_fire;
  dsfc_pkg::fifo_ctl_t  fifo_ctl;
  dsfc_pkg::entry_t     push_data;
  dsfc_pkg::entry_t     head_entry;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  dsfc_pkg::result_t    result_next;

  assign cfg_ready = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign item_fire = item_valid && item_ready;

  assign push_data.save = item.save_after;
  assign push_data.mask = item.target_mask;
  assign push_data.repeats = item.repeat_count;
  assign push_data.code = item.cmd_code;

  always_comb begin
    logic [10:0] thr [dsfc_pkg::LANES];
    logic [10:0] val [dsfc_pkg::LANES];
    logic [10:0] sat;
    logic        cmd_valid;
    logic        sent;
    dsfc_pkg::status_t status;

    thr[0] = item.throttle_0;
    thr[1] = item.throttle_1;
    thr[2] = item.throttle_2;
    thr[3] = item.throttle_3;
    cmd_valid = act_repeats != 4'd0;
    sent = 1'b0;
    status = dsfc_pkg::STATUS_OK;
    sat = '0;

    act_code_next = act_code;
    act_repeats_next = act_repeats;
    act_mask_next = act_mask;
    act_save_next = act_save;
    armed_prev_next = armed_prev;
    fifo_ctl = '0;

    for (int i = 0; i < dsfc_pkg::LANES; i++) begin
      val[i] = '0;
      if (i < dsfc_pkg::CHANNELS && 3'(i) < active_channels
          && item.op == dsfc_pkg::OP_FRAME) begin
        if (thr[i] != 11'd0) begin
          sat = (thr[i] > dsfc_pkg::MAX_THROTTLE) ? dsfc_pkg::MAX_THROTTLE : thr[i];
          val[i] = sat + dsfc_pkg::CMD_OFFSET;
        end else if (cmd_valid && act_mask[i]) begin
          val[i] = {5'b0, act_code};
          sent = 1'b1;
        end
      end
    end

    if (item.op == dsfc_pkg::OP_FRAME) begin
      if (sent) begin
        act_repeats_next = act_repeats - 1'b1;
        if (act_repeats_next == 4'd0 && act_save) begin
          act_code_next = dsfc_pkg::SAVE_CODE;
          act_repeats_next = dsfc_pkg::SAVE_REPEATS;
          act_save_next = 1'b0;
        end
      end
      if (item.armed) begin
        if (act_repeats_next != 4'd0) begin
          act_code_next = '0;
          act_repeats_next = '0;
          act_mask_next = '0;
          act_save_next = 1'b0;
        end
        fifo_ctl.clear = !armed_prev;
      end
      armed_prev_next = item.armed;
      if (!item.armed && act_repeats_next == 4'd0 && count != '0) begin
        act_code_next = head_entry.code;
        act_repeats_next = head_entry.repeats;
        act_mask_next = head_entry.mask;
        act_save_next = head_entry.save;
        fifo_ctl.pop = 1'b1;
      end
    end else begin
      if (armed_prev) begin
        status = dsfc_pkg::STATUS_ARMED;
      end else if (32'(count) >= QUEUE_DEPTH) begin
        status = dsfc_pkg::STATUS_FULL;
      end else begin
        fifo_ctl.push = 1'b1;
      end
    end

    if (!item_fire) begin
      fifo_ctl = '0;
    end

    result_next.frame_value_0 = val[0];
    result_next.frame_value_1 = val[1];
    result_next.frame_value_2 = val[2];
    result_next.frame_value_3 = val[3];
    result_next.cmd_carried = sent;
    result_next.enqueue_status = status;
    result_next.queue_level = 4'(count_next);
  end

  dsfc_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fifo_ctl),
    .push_data (push_data),
    .head_entry(head_entry),
    .count     (count),
    .count_next(count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= dsfc_pkg::ACTIVE_CHANNELS_RESET;
      act_code <= '0;
      act_repeats <= '0;
      act_mask <= '0;
      act_save <= 1'b0;
      armed_prev <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active_channels <= cfg_data;
      end
      if (item_fire) begin
        act_code <= act_code_next;
        act_repeats <= act_repeats_next;
        act_mask <= act_mask_next;
        act_save <= act_save_next;
        armed_prev <= armed_prev_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      result <= result_next;
    end
  end

endmodule

>>> test/testbench.sv
module testbench;

  localparam int ITEM_W = $bits(dsfc_pkg::item_t);

  class dshot_scoreboard;
    dsfc_pkg::result_t expected_frames[$];
    dsfc_pkg::entry_t cmd_fifo [dsfc_pkg::QUEUE_DEPTH_DEF];
    int head;
    int tail;
    int count;
    logic [5:0] code;
    logic [3:0] repeats;
    logic [3:0] mask;
    logic save;
    logic armed_prev;
    logic [2:0] lanes;
    int errors;

    function new();
      head = 0;
      tail = 0;
      count = 0;
      code = '0;
      repeats = '0;
      mask = '0;
      save = 1'b0;
      armed_prev = 1'b0;
      lanes = dsfc_pkg::ACTIVE_CHANNELS_RESET;
      errors = 0;
    endfunction

    function void set_lanes(logic [2:0] n);
      lanes = n;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function dsfc_pkg::result_t compose_frame(dsfc_pkg::item_t it);
      dsfc_pkg::result_t r;
      logic [10:0] thr [dsfc_pkg::LANES];
      logic [10:0] val [dsfc_pkg::LANES];
      logic live;
      int i;
      r = '0;
      r.enqueue_status = dsfc_pkg::STATUS_OK;
      if (it.op == dsfc_pkg::OP_FRAME) begin
        live = (repeats != 0);
        thr[0] = it.throttle_0;
        thr[1] = it.throttle_1;
        thr[2] = it.throttle_2;
        thr[3] = it.throttle_3;
        for (i = 0; i < dsfc_pkg::LANES; i++) begin
          val[i] = '0;
          if (i < dsfc_pkg::CHANNELS && i < int'(lanes)) begin
            if (thr[i] != 0) begin
              val[i] = ((thr[i] > dsfc_pkg::MAX_THROTTLE) ? dsfc_pkg::MAX_THROTTLE : thr[i])
                       + dsfc_pkg::CMD_OFFSET;
            end else if (live && mask[i]) begin
              val[i] = {5'b0, code};
              r.cmd_carried = 1'b1;
            end
          end
        end
        r.frame_value_0 = val[0];
        r.frame_value_1 = val[1];
        r.frame_value_2 = val[2];
        r.frame_value_3 = val[3];
        if (r.cmd_carried && live) begin
          repeats = repeats - 4'd1;
          if (repeats == 0 && save) begin
            code = dsfc_pkg::SAVE_CODE;
            repeats = dsfc_pkg::SAVE_REPEATS;
            save = 1'b0;
          end
        end
        if (it.armed) begin
          if (repeats != 0) begin
            code = '0;
            repeats = '0;
            mask = '0;
            save = 1'b0;
          end
          if (!armed_prev) begin
            head = 0;
            tail = 0;
            count = 0;
          end
        end
        armed_prev = it.armed;
        if (!it.armed && repeats == 0 && count != 0) begin
          code = cmd_fifo[head].code;
          repeats = cmd_fifo[head].repeats;
          mask = cmd_fifo[head].mask;
          save = cmd_fifo[head].save;
          head = (head + 1) % dsfc_pkg::QUEUE_DEPTH_DEF;
          count--;
        end
      end else begin
        if (armed_prev) begin
          r.enqueue_status = dsfc_pkg::STATUS_ARMED;
        end else if (count >= dsfc_pkg::QUEUE_DEPTH_DEF) begin
          r.enqueue_status = dsfc_pkg::STATUS_FULL;
        end else begin
          cmd_fifo[tail].code = it.cmd_code;
          cmd_fifo[tail].repeats = it.repeat_count;
          cmd_fifo[tail].mask = it.target_mask;
          cmd_fifo[tail].save = it.save_after;
          tail = (tail + 1) % dsfc_pkg::QUEUE_DEPTH_DEF;
          count++;
        end
      end
      r.queue_level = 4'(count);
      return r;
    endfunction

    function void note_item(dsfc_pkg::item_t it);
      expected_frames.push_back(compose_frame(it));
    endfunction

    function void compare(string field, logic [10:0] want, logic [10:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(dsfc_pkg::result_t got);
      dsfc_pkg::result_t want;
      if (expected_frames.size() == 0) begin
        $error("result beat with no item outstanding");
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      compare("frame_value_0", want.frame_value_0, got.frame_value_0);
      compare("frame_value_1", want.frame_value_1, got.frame_value_1);
      compare("frame_value_2", want.frame_value_2, got.frame_value_2);
      compare("frame_value_3", want.frame_value_3, got.frame_value_3);
      compare("cmd_carried", 11'(want.cmd_carried), 11'(got.cmd_carried));
      compare("enqueue_status", 11'(want.enqueue_status), 11'(got.enqueue_status));
      compare("queue_level", 11'(want.queue_level), 11'(got.queue_level));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  dsfc_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  dsfc_pkg::result_t result;

  dshot_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_pending = 1'b0;
  bit vehicle_armed = 1'b0;
  int items_sent = 0;
  logic [2:0] lane_plan [16] = '{3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd7, 3'd4, 3'd5,
                                 3'd6, 3'd2, 3'd4, 3'd3, 3'd1, 3'd4, 3'd0, 3'd4};

  dshot_frame_composer_command_queue uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(result);
      if (item_valid && item_ready) sb.note_item(item);
      if (cfg_valid && cfg_ready) sb.set_lanes(cfg_data);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [10:0] pick_throttle(int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return '0;
    r = $urandom_range(0, 9);
    if (r == 0) return 11'd1;
    if (r == 1) return dsfc_pkg::MAX_THROTTLE;
    if (r == 2) return dsfc_pkg::MAX_THROTTLE + 11'd1;
    if (r == 3) return '1;
    return 11'($urandom_range(1, 2047));
  endfunction

  function automatic dsfc_pkg::item_t frame_item(input logic [10:0] t0, t1, t2, t3,
                                                 input logic arm);
    dsfc_pkg::item_t it;
    it = ITEM_W'({$urandom, $urandom});
    it.op = dsfc_pkg::OP_FRAME;
    it.throttle_0 = t0;
    it.throttle_1 = t1;
    it.throttle_2 = t2;
    it.throttle_3 = t3;
    it.armed = arm;
    return it;
  endfunction

  function automatic dsfc_pkg::item_t command_item(input logic [5:0] c,
                                                   input logic [3:0] rep,
                                                   input logic [3:0] m, input logic s);
    dsfc_pkg::item_t it;
    it = ITEM_W'({$urandom, $urandom});
    it.op = dsfc_pkg::OP_ENQUEUE;
    it.cmd_code = c;
    it.repeat_count = rep;
    it.target_mask = m;
    it.save_after = s;
    return it;
  endfunction

  function automatic dsfc_pkg::item_t random_command();
    logic [3:0] rep;
    if ($urandom_range(0, 99) < 85) rep = 4'($urandom_range(1, 10));
    else rep = 4'($urandom_range(0, 15));
    return command_item(6'($urandom_range(0, 63)), rep, 4'($urandom_range(0, 15)),
                        $urandom_range(0, 3) == 0);
  endfunction

  function automatic dsfc_pkg::item_t quiet_frame(int zero_pct, logic arm);
    return frame_item(pick_throttle(zero_pct), pick_throttle(zero_pct),
                      pick_throttle(zero_pct), pick_throttle(zero_pct), arm);
  endfunction

  task automatic push_item(input dsfc_pkg::item_t it);
    int gap;
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_lanes(input logic [2:0] n);
    cfg_data <= n;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input int quota);
    int stop_at;
    int kind;
    int n;
    dsfc_pkg::item_t it;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // queue a batch while disarmed, then idle frames to play it out
        if (vehicle_armed) begin
          push_item(quiet_frame(50, 1'b0));
          vehicle_armed = 1'b0;
        end
        n = $urandom_range(1, 9);
        repeat (n) push_item(random_command());
        n = $urandom_range(4, 30);
        repeat (n) push_item(quiet_frame(70, 1'b0));
      end else if (kind < 8) begin
        n = $urandom_range(3, 20);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) push_item(random_command());
          else push_item(quiet_frame(20, 1'b1));
        end
        vehicle_armed = 1'b1;
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          it = ITEM_W'({$urandom, $urandom});
          if (it.op == dsfc_pkg::OP_FRAME) vehicle_armed = it.armed;
          push_item(it);
        end
      end
    end
  endtask

  initial begin : result_sink
    int r;
    forever begin
      if (hold_pending) begin
        result_ready <= 1'b0;
        repeat (120) @(posedge clk);
        hold_pending = 1'b0;
      end else if (calm) begin
        result_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          result_ready <= 1'b1;
          @(posedge clk);
        end else if (r < 97) begin
          result_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          result_ready <= 1'b0;
          repeat ($urandom_range(10, 30)) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_item(frame_item('0, '0, '0, '0, 1'b0));
    push_item(frame_item(11'd1, dsfc_pkg::MAX_THROTTLE, dsfc_pkg::MAX_THROTTLE + 11'd1,
                         '1, 1'b0));
    // zero repeat command gets dropped at the next idle check
    push_item(command_item(6'd0, 4'd0, 4'hf, 1'b0));
    push_item(command_item(6'd47, 4'd2, 4'b0101, 1'b0));
    push_item(command_item(6'd5, 4'd1, 4'hf, 1'b1));
    push_item(frame_item('0, '0, '0, '0, 1'b0));
    push_item(frame_item('0, '0, '0, '0, 1'b0));
    push_item(frame_item('0, '0, '0, '0, 1'b0));
    push_item(frame_item(11'd100, '0, '0, '0, 1'b0));
    // save request reloads the settings burst
    push_item(frame_item('0, '0, '0, '0, 1'b0));
    push_item(frame_item('0, '0, '0, '0, 1'b0));
    // arming cancels the burst
    push_item(frame_item('0, '0, '0, '0, 1'b1));
    push_item(command_item('1, '1, '1, 1'b1));
    push_item(frame_item('1, '1, '1, '1, 1'b1));
    push_item(frame_item('0, '0, '0, '0, 1'b0));
    // fill the queue past its depth
    for (k = 1; k <= dsfc_pkg::QUEUE_DEPTH_DEF + 1; k++) begin
      push_item(command_item(6'(k * 7), 4'(k), 4'(k + 6), k[0]));
    end
    drain();

    for (phase = 0; phase < 16; phase++) begin
      calm = (phase % 5 == 2);
      write_lanes(lane_plan[phase]);
      if (phase == 3) hold_pending = 1'b1;
      run_phase(95);
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("status: fail");
    $finish;
  end
endmodule

>>> filelist.f
rtl/dsfc_pkg.sv
rtl/dsfc_ram.sv
rtl/dsfc_cmd_fifo.sv
rtl/dshot_frame_composer_command_queue.sv
test/testbench.sv
